// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Same-cycle condition checked on every rising edge outside reset.
`define ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

`endif

// ===== rtl/bcbd_pkg.sv =====
// ---------------------------------------------------------------------------
// bcbd_pkg
// Shared types and constants of the block-continuation bit decoder.
// ---------------------------------------------------------------------------
package bcbd_pkg;

    localparam int STORE_BYTES_DEF    = 64;
    localparam int MAX_VALUE_BITS_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int NBITS_W = 6;
    localparam int BSIZE_W = 6;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_DATA  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [BYTE_W-1:0]  data_byte;
        logic [NBITS_W-1:0] num_bits;
        logic [BSIZE_W-1:0] block_size;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STAT_W-1:0]  status;
    } t_res;

endpackage

// ===== rtl/bcbd_store.sv =====
// ---------------------------------------------------------------------------
// bcbd_store
// Byte store: one write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module bcbd_store #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds until the next read, so the decoder can use it
    // as its current byte.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bcbd_decoder.sv =====
// ---------------------------------------------------------------------------
// bcbd_decoder
// Command sequencer and bit-serial value decoder around the byte store.
// ---------------------------------------------------------------------------
module bcbd_decoder #(
    parameter int STORE_BYTES    = 64,
    parameter int MAX_VALUE_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bcbd_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output bcbd_pkg::t_res o_res
);
    import bcbd_pkg::*;

    localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int CW  = $clog2(STORE_BYTES + 1);
    localparam int NBW = $clog2(MAX_VALUE_BITS + 1);
    localparam int MW  = MAX_VALUE_BITS + 1;

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_BIT, ST_RESULT} t_state;

    t_state r_state, n_state;
    logic [CW-1:0]             r_fill, n_fill;
    logic [CW-1:0]             r_rb, n_rb;
    logic [2:0]                r_bp, n_bp;
    logic [CW-1:0]             r_wrb, n_wrb;
    logic [2:0]                r_wbp, n_wbp;
    logic [NBW-1:0]            r_nbits, n_nbits;
    logic [BSIZE_W-1:0]        r_bsize, n_bsize;
    logic [NBW-1:0]            r_got, n_got;
    logic [NBW-1:0]            r_cnt, n_cnt;
    logic [1:0]                r_blk, n_blk;
    logic                      r_last, n_last;
    logic                      r_cont, n_cont;
    logic [MAX_VALUE_BITS-1:0] r_acc, n_acc;
    t_res                      r_res, n_res;

    logic                      w_we, w_re;
    logic [AW-1:0]             w_waddr, w_raddr;
    logic [7:0]                w_rdata;

    logic [NBW-1:0]            w_nb;
    logic [BSIZE_W-1:0]        w_bs;
    logic                      w_bit;
    logic [NBW-1:0]            w_rem;
    logic [BSIZE_W-1:0]        w_half;
    logic [MW-1:0]             w_hi, w_lo;
    logic [MAX_VALUE_BITS-1:0] w_fill_mask;

    bcbd_store #(.DEPTH(STORE_BYTES), .AW(AW)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_req.data_byte),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        if (i_req.num_bits == '0) begin
            w_nb = NBW'(1);
        end else if (i_req.num_bits > NBITS_W'(MAX_VALUE_BITS)) begin
            w_nb = NBW'(MAX_VALUE_BITS);
        end else begin
            w_nb = i_req.num_bits[NBW-1:0];
        end
        w_bs = (i_req.block_size == '0) ? BSIZE_W'(w_nb) : i_req.block_size;
    end

    assign w_bit  = w_rdata[3'd7 - r_wbp];
    assign w_rem  = r_nbits - r_got;
    assign w_half = r_bsize >> 1;
    assign w_hi   = (MW'(1) << r_nbits) - MW'(1);
    assign w_lo   = (MW'(1) << r_got) - MW'(1);
    assign w_fill_mask = MAX_VALUE_BITS'(w_hi & ~w_lo);

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_RESULT);
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        n_fill  = r_fill;
        n_rb    = r_rb;
        n_bp    = r_bp;
        n_wrb   = r_wrb;
        n_wbp   = r_wbp;
        n_nbits = r_nbits;
        n_bsize = r_bsize;
        n_got   = r_got;
        n_cnt   = r_cnt;
        n_blk   = r_blk;
        n_last  = r_last;
        n_cont  = r_cont;
        n_acc   = r_acc;
        n_res   = r_res;
        w_we    = 1'b0;
        w_waddr = r_fill[AW-1:0];
        w_re    = 1'b0;
        w_raddr = r_wrb[AW-1:0];

        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_res.value  = '0;
                    n_res.status = STAT_OK;
                    n_state      = ST_RESULT;
                    case (i_req.command)
                        CMD_CLEAR: begin
                            n_fill = '0;
                            n_rb   = '0;
                            n_bp   = '0;
                        end
                        CMD_APPEND: begin
                            if (r_fill < CW'(STORE_BYTES)) begin
                                w_we   = 1'b1;
                                n_fill = r_fill + CW'(1);
                            end else begin
                                n_res.status = STAT_FULL;
                            end
                        end
                        CMD_DECODE: begin
                            n_nbits = w_nb;
                            n_bsize = w_bs;
                            n_cnt   = (w_bs > BSIZE_W'(w_nb)) ? w_nb : w_bs[NBW-1:0];
                            n_got   = '0;
                            n_blk   = '0;
                            n_last  = 1'b0;
                            n_cont  = 1'b0;
                            n_acc   = '0;
                            n_wrb   = r_rb;
                            n_wbp   = r_bp;
                            n_state = ST_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_READ: begin
                // Fetch the byte under the working cursor, or give up with
                // the committed cursor untouched.
                if (r_wrb < r_fill) begin
                    w_re    = 1'b1;
                    n_state = ST_BIT;
                end else begin
                    n_res.value  = '0;
                    n_res.status = STAT_NO_DATA;
                    n_state      = ST_RESULT;
                end
            end

            ST_BIT: begin
                logic done;
                done  = 1'b0;
                n_wbp = r_wbp + 3'd1;
                if (r_wbp == 3'd7) begin
                    n_wrb = r_wrb + CW'(1);
                end
                if (!r_cont) begin
                    n_acc  = r_acc | (MAX_VALUE_BITS'(w_bit) << r_got);
                    n_last = w_bit;
                    n_got  = r_got + NBW'(1);
                    n_cnt  = r_cnt - NBW'(1);
                    if (r_cnt == NBW'(1)) begin
                        if (n_got < r_nbits) begin
                            n_cont = 1'b1;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end else begin
                    if (!w_bit) begin
                        done = 1'b1;
                        if (r_last) begin
                            n_acc = r_acc | w_fill_mask;
                        end
                    end else begin
                        n_cont = 1'b0;
                        n_blk  = r_blk + 2'd1;
                        if (r_blk == 2'd2) begin
                            n_bsize = BSIZE_W'(r_nbits);
                        end else if (w_half < BSIZE_W'(2)) begin
                            n_bsize = BSIZE_W'(2);
                        end else begin
                            n_bsize = w_half;
                        end
                        n_cnt = (n_bsize > BSIZE_W'(w_rem)) ? w_rem : n_bsize[NBW-1:0];
                    end
                end
                if (done) begin
                    n_rb         = n_wrb;
                    n_bp         = n_wbp;
                    n_res.value  = VALUE_W'(n_acc);
                    n_res.status = STAT_OK;
                    n_state      = ST_RESULT;
                end else if (r_wbp == 3'd7) begin
                    n_state = ST_READ;
                end
            end

            ST_RESULT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_rb    <= '0;
            r_bp    <= '0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_rb    <= n_rb;
            r_bp    <= n_bp;
        end
        r_wrb   <= n_wrb;
        r_wbp   <= n_wbp;
        r_nbits <= n_nbits;
        r_bsize <= n_bsize;
        r_got   <= n_got;
        r_cnt   <= n_cnt;
        r_blk   <= n_blk;
        r_last  <= n_last;
        r_cont  <= n_cont;
        r_acc   <= n_acc;
        r_res   <= n_res;
    end

endmodule

// ===== rtl/block_continuation_bit_decoder_top.sv =====
// ---------------------------------------------------------------------------
// block_continuation_bit_decoder_top
// Variable-length value decoder over a byte store, with stream channels.
// ---------------------------------------------------------------------------
// Each item on the slave channel is one command: clear the store, append one
// byte, or decode one value of num_bits bits starting with a block of
// block_size bits. Every item produces exactly one result item on the master
// channel, carrying the decoded value and a status code.
// Clear, append and unused commands go from the idle state to the result
// state and then into the output register. A decode sets up, then takes one
// value or continuation bit per cycle (up to 35: 32 value bits and three
// continuation bits), pausing for one read of the byte store for every byte
// the cursor enters (up to six), and then presents its result.
// The output register lets the sequencer take the next item while a result
// still waits for the receiver; if the receiver stalls longer, the sequencer
// holds its own finished result and stops accepting items.
// Reset empties the store and rewinds the read cursor at once; the byte
// store itself is not cleared and needs no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module block_continuation_bit_decoder_top #(
    parameter int STORE_BYTES    = bcbd_pkg::STORE_BYTES_DEF,
    parameter int MAX_VALUE_BITS = bcbd_pkg::MAX_VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,  // data_byte[7:0], num_bits[13:8],
                                         // block_size[19:14], zero pad
    input  logic [1:0]  i_s_axis_tuser,  // command[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // value[31:0]
    output logic [1:0]  o_m_axis_tuser   // status[1:0]
);
    import bcbd_pkg::*;

    t_req w_req;
    t_res w_res;
    logic w_res_valid;
    logic w_res_ready;

    logic r_out_valid;
    t_res r_out;

    // Unpack the slave item into the command record.
    always_comb begin
        w_req.command    = i_s_axis_tuser;
        w_req.data_byte  = i_s_axis_tdata[7:0];
        w_req.num_bits   = i_s_axis_tdata[13:8];
        w_req.block_size = i_s_axis_tdata[19:14];
    end

    bcbd_decoder #(
        .STORE_BYTES    (STORE_BYTES),
        .MAX_VALUE_BITS (MAX_VALUE_BITS)
    ) u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .o_req_ready (o_s_axis_tready),
        .i_req       (w_req),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // The output register takes a new result whenever it is empty or its
    // current item leaves in this cycle.
    assign w_res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out.value;
    assign o_m_axis_tuser  = r_out.status;

    // A failed command never carries a value.
    `ASSERT_NOW(a_err_value_zero,
        !o_m_axis_tvalid || o_m_axis_tuser == STAT_OK || o_m_axis_tdata == '0,
        "error result with non-zero value")

    // A result handed over by the sequencer is shown in the next cycle.
    `ASSERT_CLK(a_res_lands, w_res_valid && w_res_ready |=> o_m_axis_tvalid,
        "handed-over result not presented")

    // The sequencer works on one item at a time.
    `ASSERT_CLK(a_one_at_a_time, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready,
        "item accepted while another is in progress")

endmodule
